[hdl/sb64_pkg.sv]
// ----------------------------------------------------------------------------
// sb64_pkg
// Shared types and constants of the scrambled base64 string codec.
// ----------------------------------------------------------------------------
`default_nettype none

package sb64_pkg;

  localparam int unsigned MAX_RESULTS = 6;
  localparam logic [7:0]  FILL_DEFAULT = 8'hAA;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] msg_length;
    logic [7:0]  filler;
  } sb64_item_t;

  typedef struct packed {
    logic [0:MAX_RESULTS-1][7:0] bytes;
    logic [2:0]                  cnt;
    logic                        last;
  } sb64_res_t;

endpackage

`default_nettype wire

[hdl/sb64_in_if.sv]
// ----------------------------------------------------------------------------
// sb64_in_if
// Item channel into the codec: valid/ready handshake with the input fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface sb64_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  data;
  logic        first;
  logic        last;
  logic [15:0] msg_length;
  logic [7:0]  filler;

  modport source (output valid, func, data, first, last, msg_length, filler,
                  input ready);
  modport sink   (input valid, func, data, first, last, msg_length, filler,
                  output ready);
endinterface

`default_nettype wire

[hdl/sb64_out_if.sv]
// ----------------------------------------------------------------------------
// sb64_out_if
// Result channel out of the codec: valid/ready handshake with the result.
// ----------------------------------------------------------------------------
`default_nettype none

interface sb64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

`default_nettype wire

[hdl/scrambled_base64_string_codec.sv]
// ----------------------------------------------------------------------------
// scrambled_base64_string_codec
// Streaming base64 encoder/decoder with a custom alphabet and bit scramble.
//
// Channels: cmd takes one item per handshake (func selects encode of a plain
// byte or decode of a character; first/last frame a message). rsp returns
// result bytes one per handshake, out_last on the final result of a message.
// An accepted item is processed in the cycle it is taken; its results (0 to
// 6 bytes: up to 4 characters on encode, up to 6 bytes on decode) land in a
// result buffer and appear on rsp starting the next cycle, one per cycle
// while rsp.ready holds. cmd.ready is high when the buffer is empty or its
// last entry leaves in the current cycle, so items that give at most one
// result stream at one item per cycle while rsp is ready; an item with n
// results holds rsp until all n have left. An encode item gives four
// characters if it completes a group of three bytes or ends a message.
// Reset clears the buffer and the codec state (next message needs a header).
// When rsp stalls, the buffer holds and cmd.ready drops once it is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module scrambled_base64_string_codec
  import sb64_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sb64_in_if.sink   cmd,
  sb64_out_if.source rsp
);

  sb64_item_t item;
  sb64_res_t  res;
  logic       accept;
  logic       drain;

  logic [0:MAX_RESULTS-1][7:0] rbuf;
  logic                        rbuf_last;
  logic [2:0]                  pend;
  logic [2:0]                  rd_idx;

  assign item = '{func:       cmd.func,
                  data:       cmd.data,
                  first:      cmd.first,
                  last:       cmd.last,
                  msg_length: cmd.msg_length,
                  filler:     cmd.filler};

  assign drain     = rsp.valid && rsp.ready;
  assign cmd.ready = (pend == 3'd0) || (pend == 3'd1 && rsp.ready);
  assign accept    = cmd.valid && cmd.ready;

  sb64_step u_step (
    .clk  (clk),
    .rst  (rst),
    .en   (accept),
    .item (item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend   <= '0;
      rd_idx <= '0;
    end else if (accept) begin
      pend   <= res.cnt;
      rd_idx <= '0;
    end else if (drain) begin
      pend   <= pend - 3'd1;
      rd_idx <= rd_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rbuf      <= res.bytes;
      rbuf_last <= res.last;
    end
  end

  assign rsp.valid    = (pend != 3'd0);
  assign rsp.out_byte = rbuf[rd_idx];
  assign rsp.out_last = rbuf_last && (pend == 3'd1);

  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, pend} + {1'b0, rd_idx}) <= 4'd6)
    else $error("result buffer index out of range");

  a_last_at_tail: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.out_last) |-> (pend == 3'd1))
    else $error("out_last before the final buffered result");

  a_enc_last_four: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.func == FUNC_ENCODE && cmd.last) |=> (pend == 3'd4 && rbuf_last))
    else $error("encode message end did not flush a full group");

  a_enc_at_most_four: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.func == FUNC_ENCODE) |=> (pend == 3'd0 || pend == 3'd4))
    else $error("encode item gave a partial group");

endmodule

`default_nettype wire

[hdl/sb64_step.sv]
// ----------------------------------------------------------------------------
// sb64_step
// Codec state and the per-item step: group assembly, header and padding,
// held group on decode. Produces up to six result bytes per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module sb64_step
  import sb64_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire sb64_item_t item,
  output sb64_res_t       res
);

  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  logic [23:0] group_bytes, group_bytes_next;
  logic [1:0]  group_fill, group_fill_next;
  logic [23:0] held_group, held_group_next;
  logic        held_valid, held_valid_next;
  logic        header_pending, header_pending_next;
  logic [1:0]  pad_code, pad_code_next;

  function automatic logic [7:0] swap_bits(input logic [7:0] c);
    swap_bits = {c[7], c[0], c[1], c[2], c[3], c[4], c[5], c[6]};
  endfunction

  function automatic logic [7:0] to_char(input logic [5:0] i);
    logic [7:0] w;
    w = {2'b00, i};
    if (i < 6'd26)       to_char = 8'(CH_UP_A + w);
    else if (i < 6'd52)  to_char = 8'(CH_LO_A + w - 8'd26);
    else if (i < 6'd62)  to_char = 8'(CH_DIG_0 + w - 8'd52);
    else if (i == 6'd62) to_char = CH_UNDER;
    else                 to_char = CH_DOT;
  endfunction

  function automatic logic [5:0] to_index(input logic [7:0] ch);
    if (ch inside {[CH_UP_A:CH_UP_Z]})       to_index = 6'(ch - CH_UP_A);
    else if (ch inside {[CH_LO_A:CH_LO_Z]})  to_index = 6'(ch - CH_LO_A + 8'd26);
    else if (ch inside {[CH_DIG_0:CH_DIG_9]}) to_index = 6'(ch - CH_DIG_0 + 8'd52);
    else if (ch == CH_UNDER)                  to_index = 6'd62;
    else if (ch == CH_DOT)                    to_index = 6'd63;
    else                                      to_index = 6'd0;
  endfunction

  // (v + 1) mod 3, via base-4 digit sums (4 == 1 mod 3)
  function automatic logic [1:0] mod3_plus1(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    logic [1:0] m;
    s = '0;
    for (int i = 0; i < 8; i++) s = s + {3'b000, v[2*i +: 2]};
    t = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {2'b00, s[4]};
    case (t)
      3'd0, 3'd3, 3'd6: m = 2'd0;
      3'd1, 3'd4, 3'd7: m = 2'd1;
      default:          m = 2'd2;
    endcase
    mod3_plus1 = (m == 2'd2) ? 2'd0 : m + 2'd1;
  endfunction

  always_comb begin
    logic [7:0]       fl;
    logic             hp;
    logic             hv;
    logic [1:0]       gf;
    logic [23:0]      gb;
    logic [23:0]      hg;
    logic [1:0]       pad;
    logic [0:2][7:0]  grp;
    logic [23:0]      gflat;
    logic [0:5][7:0]  ob;
    logic [2:0]       n;
    logic [1:0]       start;
    logic [1:0]       stop;

    fl    = (item.filler == 8'd0) ? FILL_DEFAULT : item.filler;
    hp    = header_pending;
    hv    = held_valid;
    gf    = group_fill;
    gb    = group_bytes;
    hg    = held_group;
    pad   = pad_code;
    ob    = '0;
    n     = '0;
    grp   = '0;
    gflat = '0;
    start = '0;
    stop  = '0;

    if (item.func == FUNC_ENCODE) begin
      hp = hp | item.first;
      if (gf == 2'd3) begin
        gf = '0;
        gb = '0;
      end
      if (hp) begin
        gb  = '0;
        gf  = '0;
        hv  = 1'b0;
        pad = mod3_plus1(item.msg_length);
      end
      grp = gb;
      if (hp) begin
        grp[0] = {fl[7:2], pad};
        gf     = 2'd1;
      end
      grp[gf] = swap_bits(item.data);
      gf      = gf + 2'd1;
      if (gf == 2'd3 || item.last) begin
        for (int p = 0; p < 3; p++) begin
          if (2'(p) >= gf) grp[p] = fl;
        end
        gflat = grp;
        for (int k = 0; k < 4; k++) begin
          ob[k] = to_char(gflat[23 - 6*k -: 6]);
        end
        n  = 3'd4;
        gb = '0;
        gf = '0;
      end else begin
        gb = grp;
      end
      hp = item.last;
    end else begin
      if (item.first) begin
        hp = 1'b1;
        hv = 1'b0;
        gf = '0;
        gb = '0;
      end
      gb = {gb[17:0], to_index(item.data)};
      if (gf == 2'd3) begin
        gf = '0;
        if (hv) begin
          start = hp ? 2'd1 : 2'd0;
          for (int k = 0; k < 3; k++) begin
            if (2'(k) >= start) begin
              ob[n] = swap_bits(hg[23 - 8*k -: 8]);
              n     = n + 3'd1;
            end
          end
          hp = 1'b0;
        end
        if (hp) pad = gb[17:16];
        hg = gb;
        hv = 1'b1;
        gb = '0;
      end else begin
        gf = gf + 2'd1;
      end
      if (item.last) begin
        if (hv) begin
          start = hp ? 2'd1 : 2'd0;
          case (pad)
            2'd1:    stop = 2'd1;
            2'd2:    stop = 2'd2;
            default: stop = 2'd3;
          endcase
          for (int k = 0; k < 3; k++) begin
            if (2'(k) >= start && 2'(k) < stop) begin
              ob[n] = swap_bits(hg[23 - 8*k -: 8]);
              n     = n + 3'd1;
            end
          end
        end
        hv = 1'b0;
        hp = 1'b1;
        gf = '0;
        gb = '0;
      end
    end

    res.bytes           = ob;
    res.cnt             = n;
    res.last            = item.last && (n != 3'd0);
    group_bytes_next    = gb;
    group_fill_next     = gf;
    held_group_next     = hg;
    held_valid_next     = hv;
    header_pending_next = hp;
    pad_code_next       = pad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bytes    <= '0;
      group_fill     <= '0;
      held_group     <= '0;
      held_valid     <= 1'b0;
      header_pending <= 1'b1;
      pad_code       <= '0;
    end else if (en) begin
      group_bytes    <= group_bytes_next;
      group_fill     <= group_fill_next;
      held_group     <= held_group_next;
      held_valid     <= held_valid_next;
      header_pending <= header_pending_next;
      pad_code       <= pad_code_next;
    end
  end

endmodule

`default_nettype wire
